// File: sv/mdc_pkg.sv
// shared types and constants for the message dedup expiry cache
`timescale 1ns / 1ps

package mdc_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRECOMMIT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POSTCOMMIT = 2'd1;

  localparam logic [15:0] PRECOMMIT_RESET  = 16'd30;
  localparam logic [15:0] POSTCOMMIT_RESET = 16'd2700;

  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    VERDICT_NONE        = 2'd0,
    VERDICT_COMMITTED   = 2'd1,
    VERDICT_IN_PROGRESS = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic [15:0] precommit_expiry;
    logic [15:0] postcommit_expiry;
  } cfg_t;

  typedef struct packed {
    logic        mark;
    logic [15:0] owner;
    logic [31:0] stamp;
    logic [63:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: sv/mdc_ram.sv
// generic single-clock ram with registered read
`timescale 1ns / 1ps

module mdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/mdc_core.sv
// lookup and update sequencer for the dedup cache table
`timescale 1ns / 1ps

module mdc_core import mdc_pkg::*; #(
  parameter int TABLE_DEPTH = 16384
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [IN_DATA_W-1:0]           s_tdata,
  input  logic [IN_USER_W-1:0]           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output verdict_t                       m_verdict,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output logic [ENTRY_W-1:0]             ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  logic [ENTRY_W-1:0]             ram_rdata
);

  localparam int AW = $clog2(TABLE_DEPTH);

  state_t state, state_next;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] idx;
  logic [31:0] hash_high, hash_low, now_seconds;
  logic [15:0] requester_id;
  logic post_commit, delete_entry;

  entry_t rd_entry, wr_entry;
  logic [31:0] age;
  logic accept, lookup_done, enabled;
  logic pre_ok, post_ok, hit;
  verdict_t verdict;

  assign accept      = s_tvalid && s_tready;
  assign lookup_done = (state == ST_LOOKUP) && (!m_tvalid || m_tready);
  assign enabled     = (cfg.precommit_expiry != 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hash_high    <= s_tdata[31:0];
      hash_low     <= s_tdata[63:32];
      now_seconds  <= s_tdata[95:64];
      requester_id <= s_tdata[111:96];
      post_commit  <= s_tuser[0];
      delete_entry <= s_tuser[1];
      idx          <= ram_raddr;
    end
  end

  assign ram_re    = accept;
  assign ram_raddr = s_tdata[AW-1:0] ^ s_tdata[32 +: AW];

  assign rd_entry = entry_t'(ram_rdata);
  assign age      = now_seconds - rd_entry.stamp;
  assign pre_ok   = (age[31:16] == 16'd0) && (age[15:0] < cfg.precommit_expiry);
  assign post_ok  = (age[31:16] == 16'd0) && (age[15:0] < cfg.postcommit_expiry);
  assign hit      = (rd_entry.tag == {hash_high, hash_low}) && !age[31] &&
                    ((pre_ok && ((rd_entry.owner != requester_id) || rd_entry.mark)) ||
                     (post_ok && rd_entry.mark));

  always_comb begin
    wr_entry = rd_entry;
    verdict  = VERDICT_NONE;
    if (hit) begin
      verdict = rd_entry.mark ? VERDICT_COMMITTED : VERDICT_IN_PROGRESS;
      if (delete_entry) begin
        wr_entry.stamp = '0;
        wr_entry.owner = '0;
        wr_entry.mark  = 1'b0;
        verdict        = VERDICT_NONE;
      end
      if (post_commit && !wr_entry.mark) begin
        wr_entry.mark  = 1'b1;
        wr_entry.owner = '0;
      end
    end else begin
      wr_entry.tag = {hash_high, hash_low};
      if (delete_entry) begin
        wr_entry.stamp = '0;
        wr_entry.owner = '0;
        wr_entry.mark  = 1'b0;
      end else begin
        wr_entry.stamp = now_seconds - 32'd1;
        wr_entry.owner = post_commit ? 16'd0 : requester_id;
        wr_entry.mark  = post_commit;
      end
    end
    if (!enabled) begin
      verdict = VERDICT_NONE;
    end
  end

  assign ram_we    = (state == ST_CLEAR) || (lookup_done && enabled);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : idx;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : ENTRY_W'(wr_entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (lookup_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_done) begin
      m_verdict <= verdict;
    end
  end

`ifndef ASSERT_OFF
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !m_tvalid)
    else $error("result valid during clearing pass");

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOOKUP))
    else $error("accepted item did not enter lookup");

  a_result_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_LOOKUP))
    else $error("result raised outside lookup");
`endif

endmodule

// File: sv/message_dedup_expiry_cache.sv
// top level of the message dedup expiry cache
`timescale 1ns / 1ps

// Direct-mapped duplicate-suppression cache. For each item the core first
// latches the request and reads the table entry from the synchronous ram, then
// evaluates the hit rule, writes the entry back and loads the result register.
// The next item is taken while a result waits; a lookup holds only if the
// previous result is still not taken. After reset a clearing pass writes zero
// to every entry, one per cycle, so no item is accepted until the clearing pass
// is done; configuration writes are taken at any time.

module message_dedup_expiry_cache import mdc_pkg::*; #(
  parameter int TABLE_DEPTH = 16384
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // hash_high, hash_low, now_seconds, requester_id
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // post_commit, delete_entry
  input  logic [IN_USER_W-1:0]   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // verdict, zero pad
  output logic [OUT_DATA_W-1:0]  m_tdata
);

  localparam int AW = $clog2(TABLE_DEPTH);

  cfg_t cfg;
  verdict_t verdict;
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.precommit_expiry  <= PRECOMMIT_RESET;
      cfg.postcommit_expiry <= POSTCOMMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRECOMMIT:  cfg.precommit_expiry  <= cfg_data;
        CFG_POSTCOMMIT: cfg.postcommit_expiry <= cfg_data;
        default: ;
      endcase
    end
  end

  mdc_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_verdict (verdict),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  mdc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign m_tdata = {(OUT_DATA_W - 2)'(0), verdict};

endmodule

// File: bench/tb_message_dedup_expiry_cache.sv
// testbench for the message dedup expiry cache with a mirrored table predictor
`timescale 1ns / 1ps

module tb_message_dedup_expiry_cache;
  import mdc_pkg::*;

  localparam int DEPTH = 16384;
  localparam int STALL_LIMIT = 4 * DEPTH + 10000;

  typedef struct {
    logic [31:0] hash_high;
    logic [31:0] hash_low;
    logic [31:0] now_s;
    logic [15:0] requester;
    logic        post;
    logic        del;
  } offer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  entry_t cache_mirror [DEPTH];
  cfg_t expiry_mirror;
  offer_t offer_backlog [$];
  verdict_t verdict_due [$];
  offer_t cur_offer;
  verdict_t want;
  int queued_total = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;
  logic [31:0] wall_clock;

  message_dedup_expiry_cache #(.TABLE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic verdict_t dedup_lookup(offer_t o);
    logic [63:0] tag;
    int unsigned slot;
    logic [31:0] age;
    entry_t e;
    logic hit;
    verdict_t v;
    tag = {o.hash_high, o.hash_low};
    slot = (o.hash_high ^ o.hash_low) & (DEPTH - 1);
    v = VERDICT_NONE;
    if (expiry_mirror.precommit_expiry == 16'd0) begin
      return v;
    end
    e = cache_mirror[slot];
    age = o.now_s - e.stamp;
    hit = (e.tag == tag) && !age[31] &&
          ((age < {16'd0, expiry_mirror.precommit_expiry} &&
            (e.owner != o.requester || e.mark)) ||
           (age < {16'd0, expiry_mirror.postcommit_expiry} && e.mark));
    if (hit) begin
      v = e.mark ? VERDICT_COMMITTED : VERDICT_IN_PROGRESS;
      if (o.del) begin
        e.stamp = '0;
        e.owner = '0;
        e.mark = 1'b0;
        v = VERDICT_NONE;
      end
      if (o.post && !e.mark) begin
        e.mark = 1'b1;
        e.owner = '0;
      end
    end else begin
      e.tag = tag;
      if (o.del) begin
        e.stamp = '0;
        e.owner = '0;
        e.mark = 1'b0;
      end else begin
        e.stamp = o.now_s - 32'd1;
        e.owner = o.post ? 16'd0 : o.requester;
        e.mark = o.post;
      end
    end
    cache_mirror[slot] = e;
    return v;
  endfunction

  task automatic push_offer(input logic [31:0] hi, input logic [31:0] lo,
                            input logic [31:0] now_s, input logic [15:0] req,
                            input logic post, input logic del);
    offer_t o;
    o.hash_high = hi;
    o.hash_low = lo;
    o.now_s = now_s;
    o.requester = req;
    o.post = post;
    o.del = del;
    offer_backlog.push_back(o);
    queued_total++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PRECOMMIT) begin
      expiry_mirror.precommit_expiry = val;
    end else if (idx == CFG_POSTCOMMIT) begin
      expiry_mirror.postcommit_expiry = val;
    end
  endtask

  task automatic wait_idle(input int tail);
    while (results_seen != queued_total) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic queue_directed();
    logic [31:0] ka_hi;
    logic [31:0] ka_lo;
    logic [31:0] kb_hi;
    logic [31:0] kb_lo;
    logic [31:0] kd_hi;
    logic [31:0] kd_lo;
    logic [31:0] near_hi;
    ka_hi = 32'h1234_5678;
    ka_lo = 32'h9ABC_DEF0;
    kb_hi = 32'h0BAD_F00D;
    kb_lo = 32'h0000_0001;
    kd_hi = 32'h8000_0000;
    kd_lo = 32'h7FFF_0003;
    near_hi = 32'hDEAD_0000;
    // all-zero tag matches a cleared entry
    push_offer(32'd0, 32'd0, 32'd5, 16'd1, 1'b0, 1'b0);
    push_offer(ka_hi, ka_lo, 32'd1000, 16'd1, 1'b0, 1'b0);
    push_offer(ka_hi, ka_lo, 32'd1000, 16'd2, 1'b0, 1'b0);
    push_offer(ka_hi, ka_lo, 32'd1000, 16'd1, 1'b0, 1'b0);
    push_offer(ka_hi, ka_lo, 32'd1001, 16'd2, 1'b1, 1'b0);
    push_offer(ka_hi, ka_lo, 32'd1001, 16'd2, 1'b0, 1'b0);
    // committed entry right at the edge of its lifetime
    push_offer(ka_hi, ka_lo, 32'd3698, 16'd1, 1'b0, 1'b0);
    push_offer(ka_hi, ka_lo, 32'd3699, 16'd1, 1'b0, 1'b0);
    // time going backwards
    push_offer(ka_hi, ka_lo, 32'd3690, 16'd2, 1'b0, 1'b0);
    // another tag on the same slot evicts it
    push_offer(near_hi, near_hi ^ ka_hi ^ ka_lo ^ 32'h0010_0000, 32'd3690, 16'd2,
               1'b0, 1'b0);
    push_offer(ka_hi, ka_lo, 32'd3690, 16'd2, 1'b0, 1'b0);
    // delete on hit, then delete with commit
    push_offer(kb_hi, kb_lo, 32'd500, 16'd7, 1'b0, 1'b0);
    push_offer(kb_hi, kb_lo, 32'd501, 16'd8, 1'b0, 1'b1);
    push_offer(kb_hi, kb_lo, 32'd510, 16'd8, 1'b0, 1'b0);
    push_offer(kb_hi, kb_lo, 32'd511, 16'd9, 1'b1, 1'b1);
    push_offer(kb_hi, kb_lo, 32'd512, 16'd9, 1'b0, 1'b0);
    // delete on miss with every field at its maximum
    push_offer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
    // zero requester and stamp wrapping below zero
    push_offer(kd_hi, kd_lo, 32'd0, 16'd0, 1'b0, 1'b0);
    push_offer(kd_hi, kd_lo, 32'd0, 16'd0, 1'b0, 1'b0);
    push_offer(kd_hi, kd_lo, 32'd1, 16'd5, 1'b0, 1'b0);
    push_offer(kd_hi, kd_lo, 32'd2, 16'd0, 1'b1, 1'b0);
    push_offer(kd_hi, kd_lo, 32'd3, 16'd0, 1'b0, 1'b0);
  endtask

  task automatic queue_random(input int count, input logic [31:0] start, input int pace);
    logic [31:0] key_hi [16];
    logic [31:0] key_lo [16];
    logic [15:0] crowd [4];
    logic [31:0] now_s;
    logic [15:0] req;
    int pick;
    int roll;
    for (int k = 0; k < 16; k++) begin
      key_hi[k] = $urandom;
      key_lo[k] = $urandom;
    end
    // last four keys land on the slots of the first four
    for (int k = 12; k < 16; k++) begin
      key_lo[k] = key_hi[k] ^ (($urandom & ~32'(DEPTH - 1)) |
                               ((key_hi[k - 12] ^ key_lo[k - 12]) & 32'(DEPTH - 1)));
    end
    crowd[0] = 16'd1;
    crowd[1] = 16'd2;
    crowd[2] = 16'd3;
    crowd[3] = 16'($urandom_range(1, 65535));
    wall_clock = start;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        push_offer($urandom, $urandom, $urandom, 16'($urandom),
                   1'($urandom), 1'($urandom));
      end else begin
        pick = $urandom_range(0, 15);
        req = crowd[$urandom_range(0, 3)];
        if ($urandom_range(0, 9) == 0) begin
          req = 16'($urandom);
        end else if ($urandom_range(0, 29) == 0) begin
          req = 16'd0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 90) begin
          wall_clock = wall_clock + 32'($urandom_range(0, pace));
        end else if (roll < 97) begin
          wall_clock = wall_clock + 32'($urandom_range(5, 3000));
        end
        now_s = wall_clock;
        if ($urandom_range(0, 19) == 0) begin
          now_s = wall_clock - 32'($urandom_range(1, 200));
        end
        push_offer(key_hi[pick], key_lo[pick], now_s, req,
                   $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        verdict_due.push_back(dedup_lookup(cur_offer));
      end
      if (!s_tvalid || s_tready) begin
        if (offer_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
          cur_offer = offer_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {cur_offer.requester, cur_offer.now_s,
                      cur_offer.hash_low, cur_offer.hash_high};
          s_tuser <= {cur_offer.del, cur_offer.post};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing pending, expected none, actual %0d",
                   $time, m_tdata);
        end else begin
          want = verdict_due.pop_front();
          results_seen++;
          if (m_tdata !== OUT_DATA_W'(want)) begin
            mismatch_count++;
            $display("%0t: verdict mismatch, expected %0d, actual %0d",
                     $time, want, m_tdata);
          end
        end
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** message_dedup_expiry_cache: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      cache_mirror[k] = '0;
    end
    expiry_mirror.precommit_expiry = PRECOMMIT_RESET;
    expiry_mirror.postcommit_expiry = POSTCOMMIT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    wait_idle(4);
    queue_random(400, 32'hFFFF_FE00, 4);
    wait_idle(4);

    write_reg(CFG_PRECOMMIT, 16'd0);
    queue_random(100, $urandom, 4);
    wait_idle(4);

    // no idling on either side for this stretch
    calm = 1'b1;
    write_reg(CFG_PRECOMMIT, 16'hFFFF);
    write_reg(CFG_POSTCOMMIT, 16'hFFFF);
    queue_random(300, $urandom, 4);
    wait_idle(4);
    calm = 1'b0;

    write_reg(CFG_PRECOMMIT, 16'd1);
    write_reg(CFG_POSTCOMMIT, 16'd0);
    queue_random(250, $urandom, 1);
    wait_idle(4);

    write_reg(CFG_PRECOMMIT, 16'd5);
    write_reg(CFG_POSTCOMMIT, 16'd40);
    queue_random(300, $urandom, 1);
    wait_idle(4);

    write_reg(CFG_PRECOMMIT, 16'd40);
    write_reg(CFG_POSTCOMMIT, 16'd5);
    queue_random(300, $urandom, 2);
    wait_idle(4);

    write_reg(CFG_PRECOMMIT, 16'($urandom_range(1, 120)));
    write_reg(CFG_POSTCOMMIT, 16'($urandom_range(0, 4000)));
    queue_random(300, $urandom, 4);
    wait_idle(8);

    if (mismatch_count == 0 && verdict_due.size() == 0) begin
      $display("** message_dedup_expiry_cache: PASSED **");
    end else begin
      $display("** message_dedup_expiry_cache: FAILED **");
    end
    $finish;
  end

endmodule

// File: message_dedup_expiry_cache.f
sv/mdc_pkg.sv
sv/mdc_ram.sv
sv/mdc_core.sv
sv/message_dedup_expiry_cache.sv
bench/tb_message_dedup_expiry_cache.sv
